FILE: src/lcdrf_pkg.sv
// Package for the rectangle-fill byte stream engine: command codes and panel opcodes.
package lcdrf_pkg;

   typedef enum logic [1:0] {
      CMD_FILL      = 2'd0,
      CMD_FAST_FILL = 2'd1,
      CMD_TICK      = 2'd2,
      CMD_TICK_ALT  = 2'd3
   } cmd_type;

   localparam logic [7:0] OP_COLUMN_ADDR = 8'h2A;
   localparam logic [7:0] OP_PAGE_ADDR   = 8'h2B;
   localparam logic [7:0] OP_MEM_WRITE   = 8'h2C;

endpackage

FILE: src/lcd_rect_fill_byte_stream.sv
// Rectangle-fill byte stream engine: window setup bytes, write command and pixel bytes.
//
//   channel | ports              | direction | handshake
//   --------+--------------------+-----------+----------------------------
//   request | req_cmd .. color   | in        | req_valid / req_ready
//   response| rsp_byte_valid ..  | out       | rsp_valid / rsp_ready
//
// Every request yields one response in the cycle after its transfer; one request per cycle
// is taken as long as the response register is empty or drained in the same cycle.
// The pixel walk uses column and row counters and a byte-half flag, so one tick costs
// a single compare-and-increment between the request and the response register.
// Reset (synchronous) returns the engine to idle and empties the response register.
// A stalled response holds its register and holds off the request side.
module lcd_rect_fill_byte_stream
   import lcdrf_pkg::*;
#(
   parameter int SCREEN_WIDTH  = 320,
   parameter int SCREEN_HEIGHT = 240
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_cmd,
   input  logic [15:0] req_start_x,
   input  logic [15:0] req_start_y,
   input  logic [15:0] req_rect_width,
   input  logic [15:0] req_rect_height,
   input  logic [15:0] req_fill_color,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_byte_valid,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_data_flag,
   output logic        rsp_chip_select,
   output logic        rsp_last_byte,
   output logic        rsp_rejected
);

   localparam logic [16:0] SCR_W    = 17'(SCREEN_WIDTH);
   localparam logic [16:0] SCR_H    = 17'(SCREEN_HEIGHT);
   localparam logic [15:0] SCR_W_M1 = 16'(SCREEN_WIDTH - 1);
   localparam logic [15:0] SCR_H_M1 = 16'(SCREEN_HEIGHT - 1);

   typedef enum logic [3:0] {
      PH_COL_CMD, PH_COL_S_HI, PH_COL_S_LO, PH_COL_E_HI, PH_COL_E_LO,
      PH_PAGE_CMD, PH_ROW_S_HI, PH_ROW_S_LO, PH_ROW_E_HI, PH_ROW_E_LO,
      PH_WRITE_CMD, PH_PIXELS
   } phase_type;

   // engine state
   logic        busy_ff, busy_in;
   phase_type   phase_ff, phase_in;
   logic [15:0] col_start_ff, col_start_in, col_end_ff, col_end_in;
   logic [15:0] row_start_ff, row_start_in, row_end_ff, row_end_in;
   logic [15:0] col_ff, col_in, row_ff, row_in;
   logic        half_ff, half_in;
   logic        no_pix_ff, no_pix_in;
   logic [15:0] color_ff, color_in;
   logic        fast_ff, fast_in;

   // response register
   logic        rsp_valid_ff;
   logic        bvalid_ff, bvalid_in;
   logic [7:0]  byte_ff, byte_in;
   logic        dflag_ff, dflag_in;
   logic        cs_ff, cs_in;
   logic        last_ff, last_in;
   logic        rej_ff, rej_in;

   logic        accept;
   logic        is_start;
   logic        off_screen;
   logic [16:0] x_end, y_end;
   logic        col_last, row_last;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign is_start  = (req_cmd == CMD_FILL) || (req_cmd == CMD_FAST_FILL);

   assign off_screen = ({1'b0, req_start_x} >= SCR_W) || ({1'b0, req_start_y} >= SCR_H);
   assign x_end      = {1'b0, req_start_x} + {1'b0, req_rect_width} - 17'd1;
   assign y_end      = {1'b0, req_start_y} + {1'b0, req_rect_height} - 17'd1;
   assign col_last   = (col_ff == col_end_ff);
   assign row_last   = (row_ff == row_end_ff);

   always_comb begin
      busy_in      = busy_ff;
      phase_in     = phase_ff;
      col_start_in = col_start_ff;
      col_end_in   = col_end_ff;
      row_start_in = row_start_ff;
      row_end_in   = row_end_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      half_in      = half_ff;
      no_pix_in    = no_pix_ff;
      color_in     = color_ff;
      fast_in      = fast_ff;
      bvalid_in    = 1'b0;
      byte_in      = 8'h00;
      dflag_in     = 1'b0;
      last_in      = 1'b0;
      rej_in       = 1'b0;

      if (is_start) begin
         if (busy_ff || off_screen) begin
            rej_in = 1'b1;
         end else begin
            col_start_in = req_start_x;
            row_start_in = req_start_y;
            // clip a nonzero size at the screen edge; a zero size wraps the end
            col_end_in = (req_rect_width != 16'd0 && x_end >= SCR_W) ? SCR_W_M1 : x_end[15:0];
            row_end_in = (req_rect_height != 16'd0 && y_end >= SCR_H) ? SCR_H_M1 : y_end[15:0];
            col_in     = req_start_x;
            row_in     = req_start_y;
            half_in    = 1'b0;
            no_pix_in  = (req_rect_width == 16'd0) || (req_rect_height == 16'd0);
            color_in   = req_fill_color;
            fast_in    = (req_cmd == CMD_FAST_FILL);
            phase_in   = PH_COL_CMD;
            busy_in    = 1'b1;
         end
      end else if (busy_ff) begin
         bvalid_in = 1'b1;
         dflag_in  = 1'b1;
         if (phase_ff != PH_PIXELS) begin
            phase_in = phase_type'(phase_ff + 4'd1);
         end
         case (phase_ff)
            PH_COL_CMD:   begin byte_in = OP_COLUMN_ADDR; dflag_in = 1'b0; end
            PH_COL_S_HI:  byte_in = col_start_ff[15:8];
            PH_COL_S_LO:  byte_in = col_start_ff[7:0];
            PH_COL_E_HI:  byte_in = col_end_ff[15:8];
            PH_COL_E_LO:  byte_in = col_end_ff[7:0];
            PH_PAGE_CMD:  begin byte_in = OP_PAGE_ADDR; dflag_in = 1'b0; end
            PH_ROW_S_HI:  byte_in = row_start_ff[15:8];
            PH_ROW_S_LO:  byte_in = row_start_ff[7:0];
            PH_ROW_E_HI:  byte_in = row_end_ff[15:8];
            PH_ROW_E_LO:  byte_in = row_end_ff[7:0];
            PH_WRITE_CMD: begin
               byte_in  = OP_MEM_WRITE;
               dflag_in = 1'b0;
               last_in  = no_pix_ff;
            end
            PH_PIXELS: begin
               byte_in = (fast_ff || half_ff) ? color_ff[7:0] : color_ff[15:8];
               half_in = !half_ff;
               // advance the pixel position after its second byte
               if (half_ff) begin
                  if (col_last) begin
                     col_in = col_start_ff;
                     row_in = row_ff + 16'd1;
                  end else begin
                     col_in = col_ff + 16'd1;
                  end
               end
               last_in = half_ff && col_last && row_last;
            end
            default: begin
               byte_in = 8'h00;
            end
         endcase
         if (last_in) begin
            busy_in  = 1'b0;
            phase_in = PH_COL_CMD;
         end
      end
      cs_in = busy_ff || busy_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         phase_ff     <= PH_COL_CMD;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            busy_ff  <= busy_in;
            phase_ff <= phase_in;
         end
         if (req_ready) begin
            rsp_valid_ff <= req_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         col_start_ff <= col_start_in;
         col_end_ff   <= col_end_in;
         row_start_ff <= row_start_in;
         row_end_ff   <= row_end_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         half_ff      <= half_in;
         no_pix_ff    <= no_pix_in;
         color_ff     <= color_in;
         fast_ff      <= fast_in;
         bvalid_ff    <= bvalid_in;
         byte_ff      <= byte_in;
         dflag_ff     <= dflag_in;
         cs_ff        <= cs_in;
         last_ff      <= last_in;
         rej_ff       <= rej_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_byte_valid  = bvalid_ff;
   assign rsp_out_byte    = byte_ff;
   assign rsp_data_flag   = dflag_ff;
   assign rsp_chip_select = cs_ff;
   assign rsp_last_byte   = last_ff;
   assign rsp_rejected    = rej_ff;

`ifndef SYNTH
   a_last_has_cs: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && last_ff |-> cs_ff && bvalid_ff)
      else $error("last byte without chip select or byte");

   a_rej_no_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rej_ff |-> !bvalid_ff && !last_ff)
      else $error("rejected response carries a byte");

   a_last_idles: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && last_ff |-> !busy_ff)
      else $error("engine still busy after last byte");

   a_phase_idle: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> phase_ff == PH_COL_CMD)
      else $error("phase advanced while idle");

   a_dflag_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && dflag_ff |-> bvalid_ff)
      else $error("data flag without a byte");
`endif

endmodule
